// ===== design/tmr_pkg.sv =====
`default_nettype none
package tmr_pkg;

    localparam logic [2:0] STAT_DATA      = 3'd0;
    localparam logic [2:0] STAT_NOT_TCP   = 3'd1;
    localparam logic [2:0] STAT_BAD_OPT   = 3'd2;
    localparam logic [2:0] STAT_MALFORMED = 3'd3;
    localparam logic [2:0] STAT_IDLE      = 3'd4;

    localparam logic [7:0] PROTO_TCP   = 8'd6;
    localparam logic [7:0] OPT_END     = 8'd0;
    localparam logic [7:0] OPT_NOP     = 8'd1;
    localparam logic [7:0] OPT_MSS     = 8'd2;
    localparam logic [7:0] OPT_WSCALE  = 8'd3;
    localparam logic [7:0] OPT_SACKOK  = 8'd4;
    localparam logic [7:0] OPT_SACK    = 8'd5;
    localparam logic [7:0] OPT_TSTAMP  = 8'd8;
    localparam logic [7:0] OPT_MPTCP   = 8'd30;
    localparam logic [7:0] MSS_OPT_LEN = 8'd4;

    typedef enum logic [1:0] {
        CMD_BYTE,
        CMD_LAST,
        CMD_PULL
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK,
        S_PROTO,
        S_B0,
        S_B2,
        S_B3,
        S_DOFF,
        S_KADDR,
        S_KIND,
        S_LEN,
        S_INS,
        S_SADDR,
        S_SDAT,
        S_FOLD,
        S_RADDR,
        S_RDAT
    } t_state;

    // One's complement fold of a 32-bit sum; three folds always settle.
    function automatic logic [15:0] fold_not(input logic [31:0] acc);
        logic [31:0] a;
        a = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
        a = {16'd0, a[15:0]} + {16'd0, a[31:16]};
        a = {16'd0, a[15:0]} + {16'd0, a[31:16]};
        return ~a[15:0];
    endfunction

endpackage
`default_nettype wire

// ===== design/tcp_mss_option_rewriter.sv =====
`default_nettype none
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_mode, i_data_byte, i_last_byte
// output    out        o_out_valid / i_out_stall o_out_byte, o_out_last, o_status
//
// The back end takes packet bytes while idle. A pull passes an address and a data state
// to its result; any result holds off the next command until it has been transferred.
// The last byte starts header parsing: length check, protocol, IP header fields and data
// offset, then a walk over the options, and a checksum pass over the rewritten packet
// (one read port), plus a final step to fold the sums.
// Synchronous active-low reset empties the two-entry queue and drops any pending packet.
module tcp_mss_option_rewriter
    import tmr_pkg::*;
#(
    parameter int MAX_PACKET = 2048
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic       i_mode,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_out_last,
    output logic [2:0]      o_status,
    input  wire logic       i_mss_we,
    input  wire logic [15:0] i_mss_value
);

    logic [15:0] r_mss;
    logic        w_cmd_valid, w_cmd_pop;
    t_cmd        w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mss <= 16'd1460;
        end else if (i_mss_we) begin
            r_mss <= i_mss_value;
        end
    end

    tmr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_mode      (i_mode),
        .i_data      (i_data_byte),
        .i_last      (i_last_byte),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    tmr_back #(
        .MAX_PACKET (MAX_PACKET)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_mss       (r_mss),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_byte      (o_out_byte),
        .o_last      (o_out_last),
        .o_status    (o_status)
    );

endmodule
`default_nettype wire

// ===== design/tmr_front.sv =====
`default_nettype none
module tmr_front
    import tmr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire logic i_mode,
    input  wire logic [7:0] i_data,
    input  wire logic i_last,
    output logic      o_cmd_valid,
    output t_cmd      o_cmd,
    input  wire logic i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_in;
    logic       w_push;

    always_comb begin
        w_in.data = i_data;
        if (i_mode) begin
            w_in.kind = CMD_PULL;
        end else if (i_last) begin
            w_in.kind = CMD_LAST;
        end else begin
            w_in.kind = CMD_BYTE;
        end
    end

    assign o_stall     = (r_cnt == 2'd2);
    assign w_push      = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_cmd_pop);
        end
    end

endmodule
`default_nettype wire

// ===== design/tmr_back.sv =====
`default_nettype none
module tmr_back
    import tmr_pkg::*;
#(
    parameter int MAX_PACKET = 2048
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cmd_valid,
    input  wire t_cmd        i_cmd,
    output logic             o_cmd_pop,
    input  wire logic [15:0] i_mss,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_byte,
    output logic             o_last,
    output logic [2:0]       o_status
);

    localparam int AW = $clog2(MAX_PACKET);
    localparam int CW = $clog2(MAX_PACKET + 2);

    logic [7:0] r_mem [MAX_PACKET];
    logic [7:0] r_rdata;
    logic [AW-1:0] w_raddr;
    logic          w_we;

    t_state r_state, n_state;
    logic [CW-1:0] r_wc, n_wc, r_n, n_n;
    logic          r_ready, n_ready, r_ins, n_ins;
    logic [15:0]   r_rdidx, n_rdidx, r_outlen, n_outlen, r_tot, n_tot, r_j, n_j;
    logic [5:0]    r_ihl, n_ihl, r_hdr, n_hdr, r_i, n_i, r_mpos, n_mpos;
    logic [7:0]    r_doffb, n_doffb;
    logic [15:0]   r_mss, n_mss, r_ipck, n_ipck, r_tcpck, n_tcpck;
    logic [31:0]   r_ipacc, n_ipacc, r_tcpacc, n_tcpacc;
    logic          r_ov, n_ov, r_ol, n_ol;
    logic [7:0]    r_ob, n_ob;
    logic [2:0]    r_os, n_os;

    logic [15:0] w_vidx, w_ihl16, w_insb, w_mb, w_src;
    logic [7:0]  w_vbyte;
    logic [15:0] w_word;
    logic [8:0]  w_ilen;
    logic        w_kind_ok;

    // Virtual view of the rewritten packet over the stored bytes.
    assign w_vidx  = (r_state == S_SADDR || r_state == S_SDAT) ? r_j : r_rdidx;
    assign w_ihl16 = {10'd0, r_ihl};
    assign w_insb  = w_ihl16 + {10'd0, r_hdr};
    assign w_mb    = w_ihl16 + {10'd0, r_mpos};
    assign w_src   = (r_ins && w_vidx >= w_insb + 16'd4) ? w_vidx - 16'd4 : w_vidx;

    always_comb begin
        w_vbyte = r_rdata;
        if (w_vidx == w_mb) begin
            w_vbyte = OPT_MSS;
        end else if (w_vidx == w_mb + 16'd1) begin
            w_vbyte = MSS_OPT_LEN;
        end else if (w_vidx == w_mb + 16'd2) begin
            w_vbyte = r_mss[15:8];
        end else if (w_vidx == w_mb + 16'd3) begin
            w_vbyte = r_mss[7:0];
        end else if (w_vidx == w_ihl16 + 16'd16) begin
            w_vbyte = r_tcpck[15:8];
        end else if (w_vidx == w_ihl16 + 16'd17) begin
            w_vbyte = r_tcpck[7:0];
        end else if (r_ins) begin
            if (w_vidx == 16'd2) begin
                w_vbyte = r_tot[15:8];
            end else if (w_vidx == 16'd3) begin
                w_vbyte = r_tot[7:0];
            end else if (w_vidx == 16'd10) begin
                w_vbyte = r_ipck[15:8];
            end else if (w_vidx == 16'd11) begin
                w_vbyte = r_ipck[7:0];
            end else if (w_vidx == w_ihl16 + 16'd12) begin
                w_vbyte = {r_doffb[7:4] + 4'd1, r_doffb[3:0]};
            end
        end
    end

    assign w_word = w_vidx[0] ? {8'd0, w_vbyte} : {w_vbyte, 8'd0};
    assign w_ilen = {3'd0, r_i} + {1'b0, r_rdata};
    assign w_kind_ok = (r_rdata == OPT_WSCALE) || (r_rdata == OPT_SACKOK) ||
                       (r_rdata == OPT_SACK) || (r_rdata == OPT_TSTAMP) ||
                       (r_rdata == OPT_MPTCP);

    // Next state and datapath.
    always_comb begin
        n_state = r_state;  n_wc = r_wc;       n_n = r_n;
        n_ready = r_ready;  n_ins = r_ins;     n_rdidx = r_rdidx;
        n_outlen = r_outlen; n_tot = r_tot;    n_j = r_j;
        n_ihl = r_ihl;      n_hdr = r_hdr;     n_i = r_i;
        n_mpos = r_mpos;    n_doffb = r_doffb; n_mss = r_mss;
        n_ipck = r_ipck;    n_tcpck = r_tcpck; n_ipacc = r_ipacc;
        n_tcpacc = r_tcpacc;
        n_ov = r_ov && i_stall;
        n_ob = r_ob;  n_ol = r_ol;  n_os = r_os;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && !r_ov) begin
                    case (i_cmd.kind)
                        CMD_PULL: begin
                            if (!r_ready || r_rdidx >= r_outlen) begin
                                n_ready = 1'b0;
                                n_ov = 1'b1; n_ob = 8'd0; n_ol = 1'b0; n_os = STAT_IDLE;
                            end else begin
                                n_state = S_RADDR;
                            end
                        end
                        CMD_BYTE, CMD_LAST: begin
                            if (r_ready) begin
                                n_ready = 1'b0; n_rdidx = 16'd0; n_outlen = 16'd0;
                            end
                            if (32'(r_wc) <= 32'(MAX_PACKET)) begin
                                n_wc = r_wc + CW'(1);
                            end
                            if (i_cmd.kind == CMD_LAST) begin
                                n_n = n_wc;
                                n_wc = '0;
                                n_rdidx = 16'd0;
                                n_state = S_CHK;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CHK: begin
                if (32'(r_n) > 32'(MAX_PACKET) || 32'(r_n) < 32'd20) begin
                    n_state = S_IDLE; n_ov = 1'b1; n_ob = 8'd0; n_ol = 1'b0;
                    n_os = STAT_MALFORMED;
                end else begin
                    n_state = S_PROTO;
                end
            end
            S_PROTO: begin
                if (r_rdata != PROTO_TCP) begin
                    n_state = S_IDLE; n_ov = 1'b1; n_ob = 8'd0; n_ol = 1'b0;
                    n_os = STAT_NOT_TCP;
                end else begin
                    n_state = S_B0;
                end
            end
            S_B0: begin
                n_ihl = {r_rdata[3:0], 2'b00};
                n_state = S_B2;
            end
            S_B2: begin
                n_tot = {r_rdata, 8'd0};
                n_state = S_B3;
            end
            S_B3: begin
                n_tot = {r_tot[15:8], r_rdata};
                if (r_ihl < 6'd20 || 32'(n_tot) > 32'(r_n) ||
                    {1'b0, n_tot} < {11'd0, r_ihl} + 17'd20) begin
                    n_state = S_IDLE; n_ov = 1'b1; n_ob = 8'd0; n_ol = 1'b0;
                    n_os = STAT_MALFORMED;
                end else begin
                    n_state = S_DOFF;
                end
            end
            S_DOFF: begin
                n_doffb = r_rdata;
                n_hdr = {r_rdata[7:4], 2'b00};
                n_i = 6'd20;
                if (n_hdr < 6'd20 || {10'd0, r_ihl} + {10'd0, n_hdr} > r_tot) begin
                    n_state = S_IDLE; n_ov = 1'b1; n_ob = 8'd0; n_ol = 1'b0;
                    n_os = STAT_MALFORMED;
                end else begin
                    n_state = S_KADDR;
                end
            end
            S_KADDR: begin
                n_state = (r_i >= r_hdr) ? S_INS : S_KIND;
            end
            S_KIND: begin
                if (r_rdata == OPT_END) begin
                    n_state = S_INS;
                end else if (r_rdata == OPT_NOP) begin
                    n_i = r_i + 6'd1;
                    n_state = S_KADDR;
                end else if (r_rdata == OPT_MSS) begin
                    if ({1'b0, r_i} + 7'd4 > {1'b0, r_hdr}) begin
                        n_state = S_IDLE; n_ov = 1'b1; n_ob = 8'd0; n_ol = 1'b0;
                        n_os = STAT_MALFORMED;
                    end else begin
                        n_ins = 1'b0; n_mpos = r_i; n_mss = i_mss;
                        n_ipck = 16'd0; n_tcpck = 16'd0; n_j = 16'd0;
                        n_ipacc = 32'd0; n_tcpacc = 32'd0;
                        n_state = S_SADDR;
                    end
                end else if (!w_kind_ok) begin
                    n_state = S_IDLE; n_ov = 1'b1; n_ob = 8'd0; n_ol = 1'b0;
                    n_os = STAT_BAD_OPT;
                end else if ({1'b0, r_i} + 7'd1 >= {1'b0, r_hdr}) begin
                    n_state = S_IDLE; n_ov = 1'b1; n_ob = 8'd0; n_ol = 1'b0;
                    n_os = STAT_MALFORMED;
                end else begin
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                if (r_rdata < 8'd2 || w_ilen > {3'd0, r_hdr}) begin
                    n_state = S_IDLE; n_ov = 1'b1; n_ob = 8'd0; n_ol = 1'b0;
                    n_os = STAT_MALFORMED;
                end else begin
                    n_i = w_ilen[5:0];
                    n_state = S_KADDR;
                end
            end
            S_INS: begin
                if (r_doffb[7:4] == 4'hF || 32'(r_tot) + 32'd4 > 32'(MAX_PACKET)) begin
                    n_state = S_IDLE; n_ov = 1'b1; n_ob = 8'd0; n_ol = 1'b0;
                    n_os = STAT_MALFORMED;
                end else begin
                    n_ins = 1'b1; n_mpos = r_hdr; n_mss = i_mss;
                    n_tot = r_tot + 16'd4;
                    n_ipck = 16'd0; n_tcpck = 16'd0; n_j = 16'd0;
                    n_ipacc = 32'd0; n_tcpacc = 32'd0;
                    n_state = S_SADDR;
                end
            end
            S_SADDR: begin
                n_state = S_SDAT;
            end
            S_SDAT: begin
                if (w_vidx < w_ihl16) begin
                    n_ipacc = r_ipacc + {16'd0, w_word};
                end
                if (w_vidx >= w_ihl16 || (w_vidx >= 16'd12 && w_vidx < 16'd20)) begin
                    n_tcpacc = r_tcpacc + {16'd0, w_word};
                end
                if (r_j + 16'd1 == r_tot) begin
                    n_state = S_FOLD;
                end else begin
                    n_j = r_j + 16'd1;
                    n_state = S_SADDR;
                end
            end
            S_FOLD: begin
                n_ipck = fold_not(r_ipacc);
                n_tcpck = fold_not(r_tcpacc + 32'd6 + {16'd0, r_tot - w_ihl16});
                n_outlen = r_tot;
                n_rdidx = 16'd0;
                n_ready = 1'b1;
                n_state = S_IDLE;
            end
            S_RADDR: begin
                n_state = S_RDAT;
            end
            S_RDAT: begin
                n_ov = 1'b1; n_ob = w_vbyte; n_os = STAT_DATA;
                n_ol = (r_rdidx + 16'd1 >= r_outlen);
                n_rdidx = r_rdidx + 16'd1;
                if (n_ol) begin
                    n_ready = 1'b0;
                    n_rdidx = 16'd0;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Memory port and queue control.
    always_comb begin
        o_cmd_pop = 1'b0;
        w_we      = 1'b0;
        w_raddr   = w_src[AW-1:0];
        case (r_state)
            S_IDLE: begin
                o_cmd_pop = i_cmd_valid && !r_ov;
                w_we = o_cmd_pop && (i_cmd.kind != CMD_PULL) &&
                       (32'(r_wc) < 32'(MAX_PACKET));
            end
            S_CHK:   w_raddr = AW'(9);
            S_PROTO: w_raddr = AW'(0);
            S_B0:    w_raddr = AW'(2);
            S_B2:    w_raddr = AW'(3);
            S_B3:    w_raddr = AW'(w_ihl16 + 16'd12);
            S_KADDR: w_raddr = AW'(w_ihl16 + {10'd0, r_i});
            S_KIND:  w_raddr = AW'(w_ihl16 + {10'd0, r_i} + 16'd1);
            default: w_raddr = w_src[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_wc[AW-1:0]] <= i_cmd.data;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wc    <= '0;
            r_ready <= 1'b0;
            r_rdidx <= 16'd0;
            r_outlen <= 16'd0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wc    <= n_wc;
            r_ready <= n_ready;
            r_rdidx <= n_rdidx;
            r_outlen <= n_outlen;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n <= n_n;       r_ins <= n_ins;     r_tot <= n_tot;
        r_j <= n_j;       r_ihl <= n_ihl;     r_hdr <= n_hdr;
        r_i <= n_i;       r_mpos <= n_mpos;   r_doffb <= n_doffb;
        r_mss <= n_mss;   r_ipck <= n_ipck;   r_tcpck <= n_tcpck;
        r_ipacc <= n_ipacc; r_tcpacc <= n_tcpacc;
        r_ob <= n_ob;     r_ol <= n_ol;       r_os <= n_os;
    end

    assign o_valid  = r_ov;
    assign o_byte   = r_ob;
    assign o_last   = r_ol;
    assign o_status = r_os;

endmodule
`default_nettype wire
